### design/tdc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// Telegram deframer/checker package
// Shared types and constants for the deframer front, job queue and checker.
// -----------------------------------------------------------------------------
package tdc_pkg;

  localparam int unsigned HEAD_DEPTH = 13;
  localparam int unsigned HEAD_AW    = 4;
  localparam int unsigned VOLT_SIZE  = 11;
  localparam int unsigned PWM_SIZE   = 15;
  localparam int unsigned LEN_W      = 7;
  localparam int unsigned BODY_N     = 11;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned Q_DEPTH    = 2;

  localparam logic [CFG_IDX_W-1:0] REG_START_BYTE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_END_BYTE   = 1'd1;

  localparam logic [7:0] START_BYTE_RST = 8'd170;
  localparam logic [7:0] END_BYTE_RST   = 8'd85;

  localparam logic [2:0] ST_VALID    = 3'd0;
  localparam logic [2:0] ST_LEN_ERR  = 3'd1;
  localparam logic [2:0] ST_CHK_ERR  = 3'd2;
  localparam logic [2:0] ST_UNKNOWN  = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;

  typedef enum logic [1:0] {
    CLS_VOLT,
    CLS_PWM,
    CLS_UNKNOWN,
    CLS_OVERFLOW
  } tdc_class_e;

  // body[i] holds frame byte i + 2
  typedef struct packed {
    tdc_class_e                 cls;
    logic [LEN_W-1:0]           len;
    logic [BODY_N-1:0][7:0]     body;
  } tdc_job_t;

endpackage
`default_nettype wire

### design/telegram_deframer_checker_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// Telegram deframer/checker
// Frames received bytes on doubled start/end markers and checks each frame.
//
//   channel  signals                              role
//   cfg      cfg_valid_i/ready_o, index, data     marker register write
//   in       in_valid_i/ready_o, rx_byte_i        one received byte
//   out      out_valid_o/ready_i, status..word3   one checked frame
//
// One byte is taken every cycle while the queue has room; the front updates
// count and head in that cycle. A closed frame is written to a two-entry
// queue and from there to the checker's output register. Input stalls only
// while the queue is full. Reset clears count and previous byte and presets
// the markers; head bytes are not cleared. Config writes are always taken.
// -----------------------------------------------------------------------------
module telegram_deframer_checker_unit
  import tdc_pkg::*;
#(
  parameter int unsigned MAX_FRAME = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [7:0]           cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [7:0]           rx_byte_i,
  output logic                      out_valid_o,
  input  wire logic                 out_ready_i,
  output logic [2:0]                status_o,
  output logic                      frame_kind_o,
  output logic [LEN_W-1:0]          frame_length_o,
  output logic [15:0]               word0_o,
  output logic [15:0]               word1_o,
  output logic [15:0]               word2_o,
  output logic [15:0]               word3_o
);

  logic     fq_valid, fq_ready, qb_valid, qb_ready;
  tdc_job_t fq_job, qb_job;

  tdc_front #(
    .MAX_FRAME (MAX_FRAME)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .rx_byte_i   (rx_byte_i),
    .job_valid_o (fq_valid),
    .job_ready_i (fq_ready),
    .job_o       (fq_job)
  );

  tdc_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (fq_valid),
    .push_ready_o (fq_ready),
    .push_job_i   (fq_job),
    .pop_valid_o  (qb_valid),
    .pop_ready_i  (qb_ready),
    .pop_job_o    (qb_job)
  );

  tdc_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .job_valid_i    (qb_valid),
    .job_ready_o    (qb_ready),
    .job_i          (qb_job),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_o       (status_o),
    .frame_kind_o   (frame_kind_o),
    .frame_length_o (frame_length_o),
    .word0_o        (word0_o),
    .word1_o        (word1_o),
    .word2_o        (word2_o),
    .word3_o        (word3_o)
  );

endmodule
`default_nettype wire

### design/tdc_front.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// Telegram deframer front
// Tracks marker pairs, byte count and the frame head; issues one job per
// closed or overflowed frame.
// -----------------------------------------------------------------------------
module tdc_front
  import tdc_pkg::*;
#(
  parameter int unsigned MAX_FRAME = 64
) (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [7:0]           cfg_data_i,
  input  wire logic                 in_valid_i,
  output logic                      in_ready_o,
  input  wire logic [7:0]           rx_byte_i,
  output logic                      job_valid_o,
  input  wire logic                 job_ready_i,
  output tdc_job_t                  job_o
);

  localparam int unsigned CW = $clog2(MAX_FRAME + 2);

  logic [7:0]    start_q, end_q, prev_q;
  logic [CW-1:0] cnt_q, cnt_d, cnt_inc, cnt_mid;
  logic [CW+LEN_W-1:0] cnt_ext;
  logic [7:0]    head_q [HEAD_DEPTH];
  logic [7:0]    head_d [HEAD_DEPTH];
  logic          accept, pair_ok, restart, close, ovf;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = job_ready_i;
  assign accept      = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= START_BYTE_RST;
      end_q   <= END_BYTE_RST;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        REG_START_BYTE: start_q <= cfg_data_i;
        REG_END_BYTE:   end_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    cnt_inc = cnt_q + CW'(1);
    ovf     = cnt_inc > CW'(MAX_FRAME);
    pair_ok = cnt_q != '0;
    restart = !ovf && pair_ok && rx_byte_i == start_q && prev_q == start_q;
    cnt_mid = restart ? CW'(2) : cnt_inc;
    close   = !ovf && pair_ok && rx_byte_i == end_q && prev_q == end_q;
    cnt_d   = cnt_q;
    if (accept) begin
      cnt_d = (ovf || close) ? '0 : cnt_mid;
    end
    for (int i = 0; i < HEAD_DEPTH; i++) begin
      head_d[i] = head_q[i];
    end
    if (accept) begin
      if (cnt_q < CW'(HEAD_DEPTH)) begin
        head_d[cnt_q[HEAD_AW-1:0]] = rx_byte_i;
      end
      if (restart) begin
        head_d[0] = start_q;
        head_d[1] = start_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      prev_q <= '0;
    end else if (accept) begin
      cnt_q  <= cnt_d;
      prev_q <= rx_byte_i;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < HEAD_DEPTH; i++) begin
      head_q[i] <= head_d[i];
    end
  end

  assign cnt_ext     = (CW+LEN_W)'(cnt_mid);
  assign job_valid_o = accept && (ovf || close);

  always_comb begin
    job_o.len = cnt_ext[LEN_W-1:0];
    if (ovf) begin
      job_o.cls = CLS_OVERFLOW;
    end else if (cnt_mid == CW'(VOLT_SIZE)) begin
      job_o.cls = CLS_VOLT;
    end else if (cnt_mid == CW'(PWM_SIZE)) begin
      job_o.cls = CLS_PWM;
    end else begin
      job_o.cls = CLS_UNKNOWN;
    end
    for (int i = 0; i < BODY_N; i++) begin
      job_o.body[i] = head_d[i+2];
    end
  end

endmodule
`default_nettype wire

### design/tdc_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// Telegram job queue
// Two-entry queue between the deframer front and the checker.
// -----------------------------------------------------------------------------
module tdc_queue
  import tdc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     push_valid_i,
  output logic          push_ready_o,
  input  wire tdc_job_t push_job_i,
  output logic          pop_valid_o,
  input  wire logic     pop_ready_i,
  output tdc_job_t      pop_job_o
);

  localparam int unsigned PW = $clog2(Q_DEPTH);

  tdc_job_t          mem_q [Q_DEPTH];
  logic [PW-1:0]     wr_q, rd_q;
  logic [PW:0]       fill_q;
  logic              push, pop;

  assign push_ready_o = fill_q != (PW+1)'(Q_DEPTH);
  assign pop_valid_o  = fill_q != '0;
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;
  assign pop_job_o    = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_q] <= push_job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      if (push) begin
        wr_q <= wr_q + PW'(1);
      end
      if (pop) begin
        rd_q <= rd_q + PW'(1);
      end
      if (push && !pop) begin
        fill_q <= fill_q + (PW+1)'(1);
      end else if (pop && !push) begin
        fill_q <= fill_q - (PW+1)'(1);
      end
    end
  end

endmodule
`default_nettype wire

### design/tdc_back.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// Telegram checker
// Checks length and check byte of queued volt/PWM frames; registers results.
// -----------------------------------------------------------------------------
module tdc_back
  import tdc_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        job_valid_i,
  output logic             job_ready_o,
  input  wire tdc_job_t    job_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [2:0]       status_o,
  output logic             frame_kind_o,
  output logic [LEN_W-1:0] frame_length_o,
  output logic [15:0]      word0_o,
  output logic [15:0]      word1_o,
  output logic [15:0]      word2_o,
  output logic [15:0]      word3_o
);

  logic              valid_q;
  logic [2:0]        status_d, status_q;
  logic              kind_d, kind_q;
  logic [LEN_W-1:0]  len_d, len_q;
  logic [15:0]       w0_d, w1_d, w2_d, w3_d, w0_q, w1_q, w2_q, w3_q;
  logic [15:0]       len_field;
  logic [7:0]        sum, chk;
  logic              pwm, take;

  // body index is frame byte minus two
  always_comb begin
    pwm       = job_i.cls == CLS_PWM;
    len_field = {job_i.body[0], job_i.body[1]};
    sum       = job_i.body[1] + job_i.body[3] + job_i.body[5];
    if (pwm) begin
      sum = sum + job_i.body[7] + job_i.body[9];
    end
    chk       = pwm ? job_i.body[10] : job_i.body[6];
    status_d  = ST_VALID;
    kind_d    = 1'b0;
    len_d     = job_i.len;
    w0_d      = '0;
    w1_d      = '0;
    w2_d      = '0;
    w3_d      = '0;
    case (job_i.cls)
      CLS_OVERFLOW: begin
        status_d = ST_OVERFLOW;
        len_d    = '0;
      end
      CLS_UNKNOWN: begin
        status_d = ST_UNKNOWN;
      end
      default: begin
        kind_d = pwm;
        if (len_field != 16'(job_i.len)) begin
          status_d = ST_LEN_ERR;
        end else if (sum != chk) begin
          status_d = ST_CHK_ERR;
        end
        w0_d = {job_i.body[2], job_i.body[3]};
        w1_d = {job_i.body[4], job_i.body[5]};
        if (pwm) begin
          w2_d = {job_i.body[6], job_i.body[7]};
          w3_d = {job_i.body[8], job_i.body[9]};
        end
      end
    endcase
  end

  assign job_ready_o = !valid_q || out_ready_i;
  assign take        = job_valid_i && job_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (job_ready_o) begin
      valid_q <= job_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      status_q <= status_d;
      kind_q   <= kind_d;
      len_q    <= len_d;
      w0_q     <= w0_d;
      w1_q     <= w1_d;
      w2_q     <= w2_d;
      w3_q     <= w3_d;
    end
  end

  assign out_valid_o    = valid_q;
  assign status_o       = status_q;
  assign frame_kind_o   = kind_q;
  assign frame_length_o = len_q;
  assign word0_o        = w0_q;
  assign word1_o        = w1_q;
  assign word2_o        = w2_q;
  assign word3_o        = w3_q;

endmodule
`default_nettype wire
